// ===== rtl/core/assert_macros.svh =====
// ---------------------------------------------------------------------------
// Assertion macros shared by the RTL of the radix digit expander.
// Every macro samples on the rising edge of clock and is silent in reset.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The expression holds at every clock edge outside reset.
`define ASSERT_ALWAYS(label, expr, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (expr)) \
      else $error(msg);

// Whenever the trigger holds, the consequence holds in the same cycle.
`define ASSERT_IMPLIES(label, trig, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (trig) |-> (cons)) \
      else $error(msg);

// Whenever the trigger holds, the consequence holds in the next cycle.
`define ASSERT_NEXT(label, trig, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (trig) |=> (cons)) \
      else $error(msg);

`endif

// ===== rtl/core/rdx_pkg.sv =====
// ---------------------------------------------------------------------------
// rdx_pkg
// Types and constants of the radix digit expander.
// ---------------------------------------------------------------------------
package rdx_pkg;

   localparam int RADIX_BITS  = 8;
   localparam int DIGIT_BITS  = 8;
   localparam int POS_BITS    = 5;
   localparam int FIELD_BITS  = 32;
   localparam int MAX_DIGITS  = 32;

   localparam logic [RADIX_BITS-1:0] RADIX_RESET = 8'd10;
   localparam logic [RADIX_BITS-1:0] RADIX_MIN   = 8'd2;

   // Input word: the number to be expanded.
   typedef struct packed {
      logic [FIELD_BITS-1:0] value;
   } req_word_type;

   // Result word: one digit of the expansion.
   typedef struct packed {
      logic [DIGIT_BITS-1:0] digit;
      logic [POS_BITS-1:0]   position;
      logic [FIELD_BITS-1:0] place_value;
      logic [FIELD_BITS-1:0] term;
      logic                  last;
   } rsp_word_type;

endpackage

// ===== rtl/core/rdx_chan_if.sv =====
// ---------------------------------------------------------------------------
// rdx_chan_if
// Valid/ready channel carrying one word of a given type.
// ---------------------------------------------------------------------------
interface rdx_chan_if #(
   parameter type word_type = logic
);
   logic     valid;
   logic     ready;
   word_type word;

   modport source (output valid, output word, input ready);
   modport sink   (input valid, input word, output ready);
endinterface

// ===== rtl/core/rdx_div.sv =====
// ---------------------------------------------------------------------------
// rdx_div
// Bit-serial restoring divider: a W-bit dividend by an 8-bit divisor,
// one quotient bit per cycle.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module rdx_div #(
   parameter int W = 32
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   input  logic [W-1:0]                  dividend,
   input  logic [rdx_pkg::RADIX_BITS-1:0] divisor,
   output logic                          done,
   output logic [W-1:0]                  quotient,
   output logic [rdx_pkg::RADIX_BITS-1:0] remainder
);

   localparam int RB    = rdx_pkg::RADIX_BITS;
   localparam int CNT_W = $clog2(W + 1);

   logic              busy_ff;
   logic              done_ff;
   logic [CNT_W-1:0]  cnt_ff;
   logic [W-1:0]      quo_ff;
   logic [RB-1:0]     rem_ff;
   logic [RB-1:0]     dsr_ff;

   logic [RB:0]       trial;
   logic              ge;
   logic [RB:0]       diff;

   // The top dividend bit enters the partial remainder; the quotient
   // bit shifts in at the bottom as the dividend bits leave at the top.
   assign trial = {rem_ff, quo_ff[W-1]};
   assign ge    = trial >= {1'b0, dsr_ff};
   assign diff  = trial - {1'b0, dsr_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= busy_ff && !start && (cnt_ff == CNT_W'(1));
         if (start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= CNT_W'(W);
            quo_ff  <= dividend;
            rem_ff  <= '0;
            dsr_ff  <= divisor;
         end else if (busy_ff) begin
            quo_ff <= {quo_ff[W-2:0], ge};
            rem_ff <= ge ? diff[RB-1:0] : trial[RB-1:0];
            cnt_ff <= cnt_ff - 1'b1;
            if (cnt_ff == CNT_W'(1)) begin
               busy_ff <= 1'b0;
            end
         end
      end
   end

   assign done      = done_ff;
   assign quotient  = quo_ff;
   assign remainder = rem_ff;

   `ASSERT_IMPLIES(a_rem_below_divisor, done_ff, rem_ff < dsr_ff, "remainder not below divisor")

endmodule

// ===== rtl/core/rdx_mul.sv =====
// ---------------------------------------------------------------------------
// rdx_mul
// Shift-and-add multiplier: a W-bit multiplicand by an 8-bit multiplier,
// one multiplier bit per cycle, product kept to W bits.
// ---------------------------------------------------------------------------
module rdx_mul #(
   parameter int W = 32
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   input  logic [W-1:0]                  multiplicand,
   input  logic [rdx_pkg::RADIX_BITS-1:0] multiplier,
   output logic                          done,
   output logic [W-1:0]                  product
);

   localparam int RB    = rdx_pkg::RADIX_BITS;
   localparam int CNT_W = $clog2(RB + 1);

   logic              busy_ff;
   logic              done_ff;
   logic [CNT_W-1:0]  cnt_ff;
   logic [W-1:0]      acc_ff;
   logic [W-1:0]      mcand_ff;
   logic [RB-1:0]     mplr_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= busy_ff && !start && (cnt_ff == CNT_W'(1));
         if (start) begin
            busy_ff  <= 1'b1;
            cnt_ff   <= CNT_W'(RB);
            acc_ff   <= '0;
            mcand_ff <= multiplicand;
            mplr_ff  <= multiplier;
         end else if (busy_ff) begin
            if (mplr_ff[0]) begin
               acc_ff <= acc_ff + mcand_ff;
            end
            mcand_ff <= {mcand_ff[W-2:0], 1'b0};
            mplr_ff  <= {1'b0, mplr_ff[RB-1:1]};
            cnt_ff   <= cnt_ff - 1'b1;
            if (cnt_ff == CNT_W'(1)) begin
               busy_ff <= 1'b0;
            end
         end
      end
   end

   assign done    = done_ff;
   assign product = acc_ff;

endmodule

// ===== rtl/core/radix_digit_expander.sv =====
// ---------------------------------------------------------------------------
// radix_digit_expander
// Expands an unsigned value into its digits in a programmable radix.
// ---------------------------------------------------------------------------
// Each accepted word on req_ch is written out in the radix held in the
// configuration register (reset value 10; values 0 and 1 are treated as 2)
// as one result word per digit on rsp_ch, least significant digit first.
// A result carries the digit, its position, the place value (radix to the
// power of the position, kept to VALUE_BITS bits), the term (digit times
// place value, kept to VALUE_BITS bits) and a last flag on the most
// significant digit. An input of zero gives a single zero digit, and a run
// never exceeds 32 results. The block works on one value at a time: each
// digit is formed by the bit-serial divider (one quotient bit per cycle)
// followed by the eight-step multiplier that forms the term.
// The next place value is formed by a second multiplier while the divider
// runs. The result register lets the next digit be worked out while the
// previous one waits to be taken.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module radix_digit_expander #(
   parameter int VALUE_BITS = 32
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           csr_wr_en,
   input  logic [rdx_pkg::RADIX_BITS-1:0] csr_wr_data,
   rdx_chan_if.sink                       req_ch,
   rdx_chan_if.source                     rsp_ch
);

   localparam int W     = VALUE_BITS;
   localparam int RB    = rdx_pkg::RADIX_BITS;
   localparam int PB    = rdx_pkg::POS_BITS;
   localparam int FB    = rdx_pkg::FIELD_BITS;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_DIV,
      ST_MUL,
      ST_EMIT
   } state_type;

   state_type                 state_ff;
   logic [RB-1:0]             csr_radix_ff;
   logic [RB-1:0]             radix_ff;
   logic [W-1:0]              rest_ff;
   logic [W-1:0]              place_ff;
   logic [RB-1:0]             dig_ff;
   logic [PB-1:0]             count_ff;
   logic                      div_start_ff;
   logic                      pmul_start_ff;
   logic                      tmul_start_ff;
   logic                      rsp_valid_ff;
   rdx_pkg::rsp_word_type     rsp_word_ff;

   logic                      div_done;
   logic [W-1:0]              div_quo;
   logic [RB-1:0]             div_rem;
   logic                      pmul_done;
   logic [W-1:0]              pmul_prod;
   logic                      tmul_done;
   logic [W-1:0]              tmul_prod;

   logic                      req_take;
   logic                      slot_free;
   logic                      emit;
   logic                      last_digit;
   logic                      digit_start_in;
   logic [RB-1:0]             radix_eff;
   rdx_pkg::req_word_type     req_word;

   // The configuration register; radix values below two fall back to two.
   always_ff @(posedge clock) begin
      if (reset) begin
         csr_radix_ff <= rdx_pkg::RADIX_RESET;
      end else if (csr_wr_en) begin
         csr_radix_ff <= csr_wr_data;
      end
   end

   assign radix_eff = (csr_radix_ff < rdx_pkg::RADIX_MIN) ? rdx_pkg::RADIX_MIN : csr_radix_ff;

   assign req_word   = req_ch.word;
   assign req_take   = req_ch.valid && (state_ff == ST_IDLE);
   assign slot_free  = !rsp_valid_ff || rsp_ch.ready;
   assign emit       = (state_ff == ST_EMIT) && slot_free;

   // rest_ff already holds the quotient of the digit being emitted, so the
   // run ends when it reaches zero or when the result limit is reached.
   assign last_digit = (rest_ff == '0) || (count_ff == PB'(rdx_pkg::MAX_DIGITS - 1));

   // A digit starts on a new value or straight after a digit that is not
   // the last one has been handed to the result register.
   assign digit_start_in = req_take || (emit && !last_digit);

   // Divider: current rest by the radix gives the digit and the new rest.
   rdx_div #(.W(W)) u_div (
      .clock     (clock),
      .reset     (reset),
      .start     (div_start_ff),
      .dividend  (rest_ff),
      .divisor   (radix_ff),
      .done      (div_done),
      .quotient  (div_quo),
      .remainder (div_rem)
   );

   // Place-value multiplier: runs alongside the divider and finishes well
   // before it, so the next place value is ready when the digit is emitted.
   rdx_mul #(.W(W)) u_pmul (
      .clock        (clock),
      .reset        (reset),
      .start        (pmul_start_ff),
      .multiplicand (place_ff),
      .multiplier   (radix_ff),
      .done         (pmul_done),
      .product      (pmul_prod)
   );

   // Term multiplier: digit times the current place value.
   rdx_mul #(.W(W)) u_tmul (
      .clock        (clock),
      .reset        (reset),
      .start        (tmul_start_ff),
      .multiplicand (place_ff),
      .multiplier   (dig_ff),
      .done         (tmul_done),
      .product      (tmul_prod)
   );

   // Sequencer and result register.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         div_start_ff  <= 1'b0;
         pmul_start_ff <= 1'b0;
         tmul_start_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         div_start_ff  <= digit_start_in;
         pmul_start_ff <= digit_start_in;
         tmul_start_ff <= (state_ff == ST_DIV) && div_done;
         rsp_valid_ff  <= emit || (rsp_valid_ff && !rsp_ch.ready);
         case (state_ff)
            ST_IDLE: begin
               if (req_take) begin
                  radix_ff      <= radix_eff;
                  rest_ff       <= W'(req_word.value);
                  place_ff      <= W'(1);
                  count_ff      <= '0;
                  state_ff      <= ST_DIV;
               end
            end
            ST_DIV: begin
               if (div_done) begin
                  rest_ff       <= div_quo;
                  dig_ff        <= div_rem;
                  state_ff      <= ST_MUL;
               end
            end
            ST_MUL: begin
               if (tmul_done) begin
                  state_ff <= ST_EMIT;
               end
            end
            ST_EMIT: begin
               if (slot_free) begin
                  rsp_word_ff.digit        <= dig_ff;
                  rsp_word_ff.position     <= count_ff;
                  rsp_word_ff.place_value  <= FB'(place_ff);
                  rsp_word_ff.term         <= FB'(tmul_prod);
                  rsp_word_ff.last         <= last_digit;
                  place_ff                 <= pmul_prod;
                  count_ff                 <= count_ff + 1'b1;
                  if (last_digit) begin
                     state_ff <= ST_IDLE;
                  end else begin
                     state_ff <= ST_DIV;
                  end
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

   assign req_ch.ready = (state_ff == ST_IDLE);
   assign rsp_ch.valid = rsp_valid_ff;
   assign rsp_ch.word  = rsp_word_ff;

   `ASSERT_IMPLIES(a_div_done_in_div, div_done, state_ff == ST_DIV, "divider done out of step")
   `ASSERT_IMPLIES(a_pmul_within_div, pmul_done, state_ff == ST_DIV, "place multiplier overran")
   `ASSERT_IMPLIES(a_digit_below_radix, emit, dig_ff < radix_ff, "digit not below radix")
   `ASSERT_NEXT(a_next_start, emit && !last_digit, state_ff == ST_DIV && div_start_ff, "no restart")

endmodule

// ===== sim/tb_radix_digit_expander.sv =====
// ---------------------------------------------------------------------------
// tb_radix_digit_expander
// Self-checking bench for the radix digit expander. Values are pushed in
// over the request channel and every digit word that comes back is compared,
// field by field, with a prediction made inside the bench from the radix
// last programmed. Both channels idle at random, with some phases at full
// rate, and the radix is reprogrammed between phases while the block is idle.
// ---------------------------------------------------------------------------
module tb_radix_digit_expander;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int RB             = rdx_pkg::RADIX_BITS;
   localparam int FB             = rdx_pkg::FIELD_BITS;
   localparam int RESET_CYCLES   = 7;
   localparam int MAX_WAIT       = 10;
   // This leaves the block well clear of any work before the
   // radix is touched.
   localparam int SETTLE_CYCLES  = 100;
   // Cycles with no word accepted on either channel before the run is called
   // hung. The longest quiet stretch in a correct run is the one around a
   // radix change.
   localparam int STALL_LIMIT    = 2000;
   localparam int RANDOM_PHASES  = 10;
   localparam int VALUES_A_PHASE = 21;

   logic                  clock;
   logic                  reset;
   logic                  csr_wr_en;
   logic [RB-1:0]         csr_wr_data;

   rdx_chan_if #(.word_type(rdx_pkg::req_word_type)) req_ch ();
   rdx_chan_if #(.word_type(rdx_pkg::rsp_word_type)) rsp_ch ();

   radix_digit_expander dut (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .req_ch      (req_ch),
      .rsp_ch      (rsp_ch)
   );

   // Digit words still owed by the block, oldest first.
   rdx_pkg::rsp_word_type digits_due[$];
   // The radix as the block holds it, updated on each register write.
   logic [RB-1:0]         radix_now;
   int unsigned           mismatches;
   // When set, neither side idles: used for stretches at full rate.
   bit                    no_idle;

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   // Number of cycles a side holds off before its next word.
   function automatic int draw_wait();
      return no_idle ? 0 : $urandom_range(0, MAX_WAIT);
   endfunction

   task automatic flag_mismatch(input string note);
      $display("[%0t] mismatch: %s", $realtime, note);
      mismatches++;
   endtask

   // Works out the digit words for one value in the current radix, by the
   // same repeated division the block performs, and queues them in order.
   // A radix below two has no notation, so it is taken as two.
   function automatic void expand_value(input logic [FB-1:0] value);
      logic [RB-1:0]         base;
      logic [FB-1:0]         rest;
      logic [FB-1:0]         place;
      logic [FB-1:0]         dig;
      rdx_pkg::rsp_word_type w;
      int unsigned           count;
      bit                    done;
      base  = (radix_now < rdx_pkg::RADIX_MIN) ? rdx_pkg::RADIX_MIN : radix_now;
      rest  = value;
      place = 1;
      count = 0;
      done  = 1'b0;
      while (!done) begin
         dig           = rest % base;
         w.digit       = dig[rdx_pkg::DIGIT_BITS-1:0];
         w.position    = count[rdx_pkg::POS_BITS-1:0];
         w.place_value = place;
         w.term        = dig * place;
         rest          = rest / base;
         // With a 32-bit working width the natural end always comes by the
         // 32nd digit, but the cap is kept so the prediction mirrors the block.
         done          = (rest == 0) || (count == rdx_pkg::MAX_DIGITS - 1);
         w.last        = done;
         digits_due.push_back(w);
         place         = place * base;
         count++;
      end
   endfunction

   // Offers one value on the request channel and returns at the edge that
   // accepts it. Valid is left high so that a following word can go out
   // back to back; settle_block lowers it at the end of a phase.
   task automatic send_value(input logic [FB-1:0] value);
      int gap;
      gap = draw_wait();
      if (gap > 0) begin
         req_ch.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_ch.valid      <= 1'b1;
      req_ch.word.value <= value;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
      expand_value(value);
   endtask

   // Stops offering words, waits for every owed digit and then lets the
   // block run quiet for a while, so the radix may safely be changed.
   task automatic settle_block();
      req_ch.valid <= 1'b0;
      while (digits_due.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_radix(input logic [RB-1:0] value);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      @(posedge clock);
      csr_wr_en   <= 1'b0;
      radix_now    = value;
   endtask

   task automatic compare_field(input string name,
                                input logic [FB-1:0] seen,
                                input logic [FB-1:0] want,
                                input logic [rdx_pkg::POS_BITS-1:0] pos);
      if (seen !== want)
         flag_mismatch($sformatf("%s at position %0d: got 0x%0h, expected 0x%0h",
                                 name, pos, seen, want));
   endtask

   task automatic check_digit(input rdx_pkg::rsp_word_type got);
      rdx_pkg::rsp_word_type want;
      if (digits_due.size() == 0) begin
         flag_mismatch($sformatf("digit word 0x%0h at position %0d with nothing owed",
                                 got.digit, got.position));
      end else begin
         want = digits_due.pop_front();
         compare_field("digit", FB'(got.digit), FB'(want.digit), want.position);
         compare_field("position", FB'(got.position), FB'(want.position),
                       want.position);
         compare_field("place value", got.place_value, want.place_value, want.position);
         compare_field("term", got.term, want.term, want.position);
         compare_field("last flag", FB'(got.last), FB'(want.last), want.position);
      end
   endtask

   // Values in the radix the block comes out of reset with: zero, the edges
   // of one and two decimal digits, the widest value and a ten-digit value.
   task automatic test_reset_radix();
      send_value(32'd0);
      send_value(32'd9);
      send_value(32'd10);
      send_value(32'd99);
      send_value(32'd100);
      send_value(32'hFFFF_FFFF);
      send_value(32'd1234567890);
      settle_block();
   endtask

   // The smallest and largest meaningful radix. Radix two on an all-ones
   // value gives the longest run the block can produce, 32 digits.
   task automatic test_radix_extremes();
      write_radix(rdx_pkg::RADIX_MIN);
      send_value(32'd1);
      send_value(32'hFFFF_FFFF);
      send_value(32'h8000_0000);
      settle_block();
      write_radix(8'd255);
      send_value(32'd254);
      send_value(32'd255);
      send_value(32'd65025);
      send_value(32'hFFFF_FFFF);
      settle_block();
   endtask

   // A radix of zero or one must be treated as radix two.
   task automatic test_degenerate_radix();
      write_radix(8'd0);
      send_value(32'd0);
      send_value(32'd6);
      send_value(32'hFFFF_FFFF);
      settle_block();
      write_radix(8'd1);
      send_value(32'd13);
      send_value(32'd0);
      settle_block();
   endtask

   // Phases of random values, each in its own radix. The first few radix
   // settings are fixed so that every bit of the register is seen in both
   // states; the rest, zero and one included, are drawn at random.
   task automatic test_random_values();
      logic [RB-1:0] r;
      logic [FB-1:0] v;
      for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
         case (phase)
            0: r = 8'd16;
            1: r = 8'd2;
            2: r = 8'd255;
            3: r = 8'd3;
            4: r = 8'h55;
            5: r = 8'hAA;
            default: r = RB'($urandom_range(0, 255));
         endcase
         write_radix(r);
         // About one phase in four runs with no idling on either side.
         no_idle = ($urandom_range(0, 3) == 0);
         for (int n = 0; n < VALUES_A_PHASE; n++) begin
            // Mix full-width values with shorter and very small ones, so runs
            // of every length turn up and not only the longest.
            case ($urandom_range(0, 2))
               0: v = $urandom;
               1: v = $urandom >> $urandom_range(1, 31);
               default: v = $urandom_range(0, 600);
            endcase
            send_value(v);
         end
         settle_block();
         no_idle = 1'b0;
      end
   endtask

   // Main sequence: reset once, then each test in turn, then the verdict.
   initial begin
      reset        <= 1'b1;
      csr_wr_en    <= 1'b0;
      csr_wr_data  <= '0;
      req_ch.valid <= 1'b0;
      req_ch.word  <= '0;
      radix_now     = rdx_pkg::RADIX_RESET;
      mismatches    = 0;
      no_idle       = 1'b0;
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      test_reset_radix();
      test_radix_extremes();
      test_degenerate_radix();
      test_random_values();

      // settle_block has already drained the owed digits and waited out the
      // block's latency, so any stray word would have been flagged by now.
      if (mismatches == 0)
         $display("tb_radix_digit_expander: PASS");
      else
         $display("tb_radix_digit_expander: FAIL");
      $finish;
   end

   // Result side: holds ready low for a random number of cycles before each
   // word, then takes the word and checks it against the oldest prediction.
   initial begin : digit_receiver
      int stall;
      rsp_ch.ready <= 1'b0;
      repeat (RESET_CYCLES + 1) @(posedge clock);
      forever begin
         stall = draw_wait();
         if (stall > 0) begin
            rsp_ch.ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_ch.ready <= 1'b1;
         @(posedge clock);
         while (!rsp_ch.valid) @(posedge clock);
         check_digit(rsp_ch.word);
      end
   end

   // Ends the run if neither channel moves a word for too long.
   initial begin : stall_watchdog
      int unsigned quiet;
      quiet = 0;
      forever begin
         @(posedge clock);
         if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
            quiet = 0;
         else
            quiet++;
         if (quiet >= STALL_LIMIT) begin
            $display("tb_radix_digit_expander: FAIL");
            $finish;
         end
      end
   end

endmodule
